>>> design/tit_pkg.sv
`timescale 1ns / 1ps

package tit_pkg;

  // default sizing of the table
  localparam int DEPTH_DEF = 16;
  localparam int TIME_DEF  = 48;
  localparam int TAG_DEF   = 16;

  // port field widths
  localparam int KIND_W   = 2;
  localparam int TIME_W   = 48;
  localparam int TAG_W    = 16;
  localparam int FROM_W   = 4;
  localparam int STATUS_W = 3;
  localparam int POS_W    = 4;
  localparam int ID_W     = 32;
  localparam int COUNT_W  = 5;

  // packed stream widths, rounded up to whole bytes
  localparam int IN_DATA_W  = 168;
  localparam int OUT_DATA_W = 160;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD    = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_ORDER    = 3'd1,
    ST_ZERO     = 3'd2,
    ST_OVERLAP  = 3'd3,
    ST_FULL     = 3'd4,
    ST_NO_MATCH = 3'd5
  } status_t;

  // which entry the result shows
  typedef enum logic [1:0] {
    SHOW_NONE = 2'd0,
    SHOW_WORK = 2'd1,
    SHOW_READ = 2'd2
  } show_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic pre;
    logic scan;
    logic shift;
    logic write;
    logic result;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pre_fin;
    logic pre_write;
    logic scan_fin;
    logic scan_shift;
    logic scan_write;
    logic shift_last;
  } sts_t;

endpackage

>>> design/tit_ctrl.sv
`timescale 1ns / 1ps

module tit_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  tit_pkg::sts_t sts,
  output tit_pkg::cmd_t cmd
);
  import tit_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PRE   = 6'b000010,
    S_SCAN  = 6'b000100,
    S_SHIFT = 6'b001000,
    S_WRITE = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  // sequencing
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_PRE;
        end
      end
      S_PRE: begin
        cmd.pre = 1'b1;
        priority if (sts.pre_fin) state_next = S_FIN;
        else if (sts.pre_write)   state_next = S_WRITE;
        else                      state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        priority if (sts.scan_fin) state_next = S_FIN;
        else if (sts.scan_shift)   state_next = S_SHIFT;
        else if (sts.scan_write)   state_next = S_WRITE;
        else                       state_next = S_SCAN;
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (sts.shift_last) state_next = S_WRITE;
      end
      S_WRITE: begin
        cmd.write  = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          cmd.result = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // result slot
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

>>> design/tit_dp.sv
`timescale 1ns / 1ps

module tit_dp #(
  parameter int TABLE_DEPTH = tit_pkg::DEPTH_DEF,
  parameter int TIME_BITS   = tit_pkg::TIME_DEF,
  parameter int TAG_BITS    = tit_pkg::TAG_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tit_pkg::cmd_t                 cmd,
  output tit_pkg::sts_t                 sts,
  input  logic [tit_pkg::KIND_W-1:0]    kind,
  input  logic [tit_pkg::TIME_W-1:0]    new_start,
  input  logic [tit_pkg::TIME_W-1:0]    new_end,
  input  logic [tit_pkg::TAG_W-1:0]     new_tag,
  input  logic [tit_pkg::TIME_W-1:0]    elapsed,
  input  logic [tit_pkg::FROM_W-1:0]    search_from,
  output logic [tit_pkg::STATUS_W-1:0]  status,
  output logic [tit_pkg::POS_W-1:0]     position,
  output logic [tit_pkg::ID_W-1:0]      entry_id,
  output logic [tit_pkg::TIME_W-1:0]    entry_start,
  output logic [tit_pkg::TIME_W-1:0]    entry_end,
  output logic [tit_pkg::TAG_W-1:0]     entry_tag,
  output logic [tit_pkg::COUNT_W-1:0]   entry_count
);
  import tit_pkg::*;

  localparam int AW   = $clog2(TABLE_DEPTH);
  localparam int CW   = $clog2(TABLE_DEPTH + 1);
  localparam int CMPW = CW + FROM_W;

  typedef struct packed {
    logic [TIME_BITS-1:0] start;
    logic [TIME_BITS-1:0] stop;
    logic [TAG_BITS-1:0]  tag;
    logic [ID_W-1:0]      serial;
  } entry_t;

  // table storage, one write and one registered read port
  entry_t mem [TABLE_DEPTH];
  entry_t rd;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;

  // item under work
  kind_t                op;
  logic [TIME_BITS-1:0] ns;
  logic [TIME_BITS-1:0] ne;
  logic [TIME_BITS-1:0] el;
  logic [TAG_BITS-1:0]  tg;
  logic [FROM_W-1:0]    from;
  logic                 open_s;
  logic [CW-1:0]        idx;
  logic [CW-1:0]        pos;
  logic [ID_W-1:0]      sid;
  status_t              st;
  show_t                show;

  // table state
  logic [CW-1:0]   held;
  logic [ID_W-1:0] serial_ctr;

  logic is_add;
  logic is_look;
  logic bad_order;
  logic bad_zero;
  logic full;
  logic from_out;
  logic last;
  logic zz;
  logic place_here;
  logic a_fail;
  logic hit;

  assign is_add  = (op == KIND_ADD);
  assign is_look = (op == KIND_LOOKUP);

  // checks ahead of the walk
  assign bad_order = (ne != '0) && (ne <= ns);
  assign bad_zero  = (ns == '0) && (ne == '0) && (held != '0);
  assign full      = (held >= CW'(TABLE_DEPTH));
  assign from_out  = (CMPW'(from) >= CMPW'(held));

  // one entry of the walk, rd holds entry idx
  assign last       = ((idx + CW'(1)) == held);
  assign zz         = (rd.start == '0) && (rd.stop == '0);
  assign place_here = open_s ? (rd.start != '0) : (ns < rd.start);
  always_comb begin
    if (zz) begin
      a_fail = 1'b1;
    end else if (open_s) begin
      a_fail = (rd.start != '0) ? (ne > rd.start) : (ne <= rd.stop);
    end else if (ns < rd.start) begin
      a_fail = (ne != '0) && (ne > rd.start);
    end else begin
      a_fail = (ns < rd.stop) || (rd.stop == '0);
    end
  end
  assign hit = ((rd.start == '0) || (el >= rd.start)) && ((rd.stop == '0) || (el < rd.stop));

  // status to the controller
  always_comb begin
    sts.pre_fin    = !(is_add || is_look) || (is_add && (bad_order || bad_zero || full))
                     || (is_look && from_out);
    sts.pre_write  = is_add && (held == '0);
    sts.scan_fin   = is_add ? a_fail : (hit || last);
    sts.scan_shift = is_add && !a_fail && place_here;
    sts.scan_write = is_add && !a_fail && !place_here && last;
    sts.shift_last = (idx == (pos + CW'(1)));
  end

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = AW'(idx);
    wr_data = rd;
    if (cmd.pre) begin
      rd_en   = 1'b1;
      rd_addr = is_look ? AW'(from) : '0;
    end else if (cmd.scan) begin
      rd_en   = !(is_look && hit);
      rd_addr = (is_add && place_here) ? AW'(held - CW'(1)) : AW'(idx + CW'(1));
    end else if (cmd.shift) begin
      rd_en   = 1'b1;
      rd_addr = AW'(idx - CW'(2));
      wr_en   = 1'b1;
    end else if (cmd.write) begin
      wr_en   = 1'b1;
      wr_addr = AW'(pos);
      wr_data = '{start: ns, stop: ne, tag: tg, serial: serial_ctr};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd <= mem[rd_addr];
  end

  // fill count and serial counter
  always_ff @(posedge clk) begin
    if (rst) begin
      held       <= '0;
      serial_ctr <= '0;
    end else begin
      if (cmd.pre && (op == KIND_CLEAR)) held <= '0;
      if (cmd.write) begin
        held       <= held + CW'(1);
        serial_ctr <= serial_ctr + ID_W'(1);
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op   <= kind_t'(kind);
      ns   <= TIME_BITS'(new_start);
      ne   <= TIME_BITS'(new_end);
      tg   <= TAG_BITS'(new_tag);
      el   <= TIME_BITS'(elapsed);
      from <= search_from;
    end
    if (cmd.pre) begin
      open_s <= (ns == '0);
      show   <= SHOW_NONE;
      pos    <= '0;
      idx    <= is_look ? CW'(from) : '0;
      priority if (is_add && bad_order) st <= ST_ORDER;
      else if (is_add && bad_zero)      st <= ST_ZERO;
      else if (is_add && full)          st <= ST_FULL;
      else if (is_look && from_out)     st <= ST_NO_MATCH;
      else                              st <= ST_OK;
    end
    if (cmd.scan) begin
      if (is_add) begin
        if (a_fail) begin
          st <= ST_OVERLAP;
        end else if (place_here) begin
          pos <= idx;
          idx <= held;
          if (!open_s && (ne == '0)) ne <= rd.start;
        end else begin
          // open start slides to the end of an entry starting at zero
          if (open_s) begin
            ns     <= rd.stop;
            open_s <= 1'b0;
          end
          if (last) pos <= held;
          else      idx <= idx + CW'(1);
        end
      end else begin
        if (hit) begin
          pos  <= idx;
          show <= SHOW_READ;
        end else if (last) begin
          st <= ST_NO_MATCH;
        end else begin
          idx <= idx + CW'(1);
        end
      end
    end
    if (cmd.shift) idx <= idx - CW'(1);
    if (cmd.write) begin
      sid  <= serial_ctr;
      show <= SHOW_WORK;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.result) begin
      status      <= st;
      entry_count <= COUNT_W'(held);
      unique case (show)
        SHOW_WORK: begin
          position    <= POS_W'(pos);
          entry_id    <= sid;
          entry_start <= TIME_W'(ns);
          entry_end   <= TIME_W'(ne);
          entry_tag   <= TAG_W'(tg);
        end
        SHOW_READ: begin
          position    <= POS_W'(pos);
          entry_id    <= rd.serial;
          entry_start <= TIME_W'(rd.start);
          entry_end   <= TIME_W'(rd.stop);
          entry_tag   <= TAG_W'(rd.tag);
        end
        default: begin
          position    <= '0;
          entry_id    <= '0;
          entry_start <= '0;
          entry_end   <= '0;
          entry_tag   <= '0;
        end
      endcase
    end
  end

  // checks
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held <= CW'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

  a_write_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.write |=> (held == $past(held) + CW'(1)))
    else $error("insert did not grow the table by one");

  a_shift_range: assert property (@(posedge clk) disable iff (rst)
    cmd.shift |-> (idx > pos))
    else $error("shift ran past the insert position");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    cmd.scan |-> (idx < held))
    else $error("walk beyond the held entries");

endmodule

>>> design/time_interval_table.sv
`timescale 1ns / 1ps

// Sorted table of up to TABLE_DEPTH non-overlapping time intervals, one
// request beat in and one result beat out per item. The block works on one
// item at a time, walking the table one entry per cycle through a memory with
// one read and one write port. After the request beat is accepted, a clear
// goes from its check step straight to loading the result; a lookup or an
// add that passes the checks first scans any held entries, and a successful
// add then shifts the entries after its slot toward the tail and writes the
// new entry (scans and shifts together never exceed TABLE_DEPTH). The next
// request is taken in the cycle after the result is loaded, even if that
// result has not been taken yet. Loading a result waits while the previous
// result is still unread in the output register. Table contents are not
// cleared at reset; only entries below the fill count ever reach a result.
module time_interval_table #(
  parameter int TABLE_DEPTH = tit_pkg::DEPTH_DEF,
  parameter int TIME_BITS   = tit_pkg::TIME_DEF,
  parameter int TAG_BITS    = tit_pkg::TAG_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // new_start, new_end, new_tag, elapsed, search_from, zero pad
  input  logic [tit_pkg::IN_DATA_W-1:0]    s_tdata,
  // kind
  input  logic [tit_pkg::KIND_W-1:0]       s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // status, position, entry_id, entry_start, entry_end, entry_tag,
  // entry_count, zero pad
  output logic [tit_pkg::OUT_DATA_W-1:0]   m_tdata
);
  import tit_pkg::*;

  cmd_t cmd;
  sts_t sts;

  logic [STATUS_W-1:0] status;
  logic [POS_W-1:0]    position;
  logic [ID_W-1:0]     entry_id;
  logic [TIME_W-1:0]   entry_start;
  logic [TIME_W-1:0]   entry_end;
  logic [TAG_W-1:0]    entry_tag;
  logic [COUNT_W-1:0]  entry_count;

  tit_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tit_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .TIME_BITS   (TIME_BITS),
    .TAG_BITS    (TAG_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .kind        (s_tuser),
    .new_start   (s_tdata[47:0]),
    .new_end     (s_tdata[95:48]),
    .new_tag     (s_tdata[111:96]),
    .elapsed     (s_tdata[159:112]),
    .search_from (s_tdata[163:160]),
    .status      (status),
    .position    (position),
    .entry_id    (entry_id),
    .entry_start (entry_start),
    .entry_end   (entry_end),
    .entry_tag   (entry_tag),
    .entry_count (entry_count)
  );

  // result beat packing
  assign m_tdata = {4'b0, entry_count, entry_tag, entry_end, entry_start,
                    entry_id, position, status};

endmodule

>>> tb/sv/time_interval_table_tb.sv
`timescale 1ns / 1ps

module time_interval_table_tb;
  import tit_pkg::*;

  localparam int TABLE_DEPTH  = DEPTH_DEF;
  localparam int RANDOM_ITEMS = 1230;
  localparam int CALM_ITEMS   = 100;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 60;
  localparam int PRINT_CAP    = 40;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  typedef struct {
    kind_t             kind;
    logic [TIME_W-1:0] new_start;
    logic [TIME_W-1:0] new_end;
    logic [TAG_W-1:0]  new_tag;
    logic [TIME_W-1:0] elapsed;
    logic [FROM_W-1:0] search_from;
  } request_t;

  typedef struct {
    status_t            status;
    logic [POS_W-1:0]   position;
    logic [ID_W-1:0]    entry_id;
    logic [TIME_W-1:0]  entry_start;
    logic [TIME_W-1:0]  entry_end;
    logic [TAG_W-1:0]   entry_tag;
    logic [COUNT_W-1:0] entry_count;
  } result_t;

  // one line of the directed plan; fixed is set where the result is typed in
  typedef struct {
    request_t rq;
    bit       fixed;
    result_t  want;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [KIND_W-1:0]     s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  // shadow copy of the interval table
  logic [TIME_W-1:0] tbl_start [TABLE_DEPTH];
  logic [TIME_W-1:0] tbl_end [TABLE_DEPTH];
  logic [TAG_W-1:0]  tbl_tag [TABLE_DEPTH];
  logic [ID_W-1:0]   tbl_serial [TABLE_DEPTH];
  int                held = 0;
  logic [ID_W-1:0]   serial_next = '0;

  result_t pending_results[$];
  result_t seen;
  result_t want;
  int      errors = 0;
  int      quiet_cycles = 0;
  int      win_bits = 16;
  bit      tx_gaps = 1'b1;
  bit      calm = 1'b0;
  bit      hold_req = 1'b0;

  time_interval_table uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [TIME_W-1:0] rand48();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[TIME_W-1:0];
  endfunction

  function automatic request_t request(kind_t kind, logic [TIME_W-1:0] t0,
                                       logic [TIME_W-1:0] t1, logic [TAG_W-1:0] tag,
                                       logic [TIME_W-1:0] at, logic [FROM_W-1:0] from);
    request_t rq;
    rq.kind = kind;
    rq.new_start = t0;
    rq.new_end = t1;
    rq.new_tag = tag;
    rq.elapsed = at;
    rq.search_from = from;
    return rq;
  endfunction

  function automatic result_t outcome(status_t st, logic [POS_W-1:0] pos,
                                      logic [ID_W-1:0] id, logic [TIME_W-1:0] t0,
                                      logic [TIME_W-1:0] t1, logic [TAG_W-1:0] tag,
                                      logic [COUNT_W-1:0] cnt);
    result_t r;
    r.status = st;
    r.position = pos;
    r.entry_id = id;
    r.entry_start = t0;
    r.entry_end = t1;
    r.entry_tag = tag;
    r.entry_count = cnt;
    return r;
  endfunction

  function automatic logic [IN_DATA_W-1:0] pack_request(request_t rq);
    return {4'b0, rq.search_from, rq.elapsed, rq.new_tag, rq.new_end, rq.new_start};
  endfunction

  function automatic result_t unpack_result(logic [OUT_DATA_W-1:0] d);
    return outcome(status_t'(d[2:0]), d[6:3], d[38:7], d[86:39], d[134:87],
                   d[150:135], d[155:151]);
  endfunction

  // Applies one request to the shadow table and returns the result beat it
  // should produce.
  function automatic result_t apply_request(request_t rq);
    result_t         r;
    logic [TIME_W-1:0] ns, ne, s, e;
    logic            open_start, stop, shown;
    int              pos, hit;
    r = outcome(ST_OK, '0, '0, '0, '0, '0, '0);
    shown = 1'b0;
    hit = 0;
    case (rq.kind)
      KIND_ADD: begin
        ns = rq.new_start;
        ne = rq.new_end;
        open_start = (ns == 0);
        pos = held;
        stop = 1'b0;
        if (ne != 0 && ne <= ns) r.status = ST_ORDER;
        else if (ns == 0 && ne == 0 && held > 0) r.status = ST_ZERO;
        else if (held >= TABLE_DEPTH) r.status = ST_FULL;
        else begin
          // walk the sorted entries until the slot is found or a clash shows
          for (int i = 0; i < held && !stop; i++) begin
            s = tbl_start[i];
            e = tbl_end[i];
            if (s == 0 && e == 0) begin
              r.status = ST_OVERLAP;
              stop = 1'b1;
            end else if (open_start) begin
              if (s != 0) begin
                if (ne > s) r.status = ST_OVERLAP;
                else pos = i;
                stop = 1'b1;
              end else if (ne <= e) begin
                r.status = ST_OVERLAP;
                stop = 1'b1;
              end else begin
                // open start snaps to the end of the earlier entry
                ns = e;
                open_start = 1'b0;
              end
            end else if (ns < s) begin
              if (ne == 0) ne = s;
              else if (ne > s) r.status = ST_OVERLAP;
              pos = i;
              stop = 1'b1;
            end else if (ns < e || e == 0) begin
              r.status = ST_OVERLAP;
              stop = 1'b1;
            end
          end
        end
        if (r.status == ST_OK) begin
          for (int k = held; k > pos; k--) begin
            tbl_start[k] = tbl_start[k-1];
            tbl_end[k] = tbl_end[k-1];
            tbl_tag[k] = tbl_tag[k-1];
            tbl_serial[k] = tbl_serial[k-1];
          end
          tbl_start[pos] = ns;
          tbl_end[pos] = ne;
          tbl_tag[pos] = rq.new_tag;
          tbl_serial[pos] = serial_next;
          serial_next = serial_next + 1'b1;
          held++;
          hit = pos;
          shown = 1'b1;
        end
      end
      KIND_LOOKUP: begin
        r.status = ST_NO_MATCH;
        for (int i = rq.search_from; i < held && !shown; i++) begin
          if ((tbl_start[i] == 0 || rq.elapsed >= tbl_start[i]) &&
              (tbl_end[i] == 0 || rq.elapsed < tbl_end[i])) begin
            r.status = ST_OK;
            hit = i;
            shown = 1'b1;
          end
        end
      end
      KIND_CLEAR: held = 0;
      default: ;
    endcase
    if (shown) begin
      r.position = POS_W'(hit);
      r.entry_id = tbl_serial[hit];
      r.entry_start = tbl_start[hit];
      r.entry_end = tbl_end[hit];
      r.entry_tag = tbl_tag[hit];
    end
    r.entry_count = COUNT_W'(held);
    return r;
  endfunction

  // Random request, mostly adds of intervals in a window that shrinks or
  // grows at each clear, and lookups aimed at held entries.
  function automatic request_t make_request();
    request_t          rq;
    logic [TIME_W-1:0] mask;
    int                roll, j;
    rq = request(KIND_ADD, rand48(), rand48(), TAG_W'($urandom()), rand48(),
                 FROM_W'($urandom()));
    mask = (win_bits >= TIME_W) ? TIME_MAX : ((TIME_W'(1) << win_bits) - 1'b1);
    roll = $urandom_range(0, 99);
    if (roll < 2 || (held == TABLE_DEPTH && roll < 30)) begin
      rq.kind = KIND_CLEAR;
      win_bits = $urandom_range(6, TIME_W);
    end else if (roll < 3) begin
      rq.kind = KIND_NONE;
    end else if (roll < 40) begin
      rq.kind = KIND_LOOKUP;
      if (held != 0 && $urandom_range(0, 4) != 0) begin
        j = $urandom_range(0, held - 1);
        case ($urandom_range(0, 3))
          0: rq.elapsed = tbl_start[j];
          1: rq.elapsed = tbl_end[j];
          default: begin
            if (tbl_end[j] > tbl_start[j])
              rq.elapsed = tbl_start[j] + rand48() % (tbl_end[j] - tbl_start[j]);
            else
              rq.elapsed = tbl_start[j] + (rand48() & mask);
          end
        endcase
        if ($urandom_range(0, 3) != 0) rq.search_from = FROM_W'($urandom_range(0, j));
      end
    end else begin
      rq.new_start = rand48() & mask;
      rq.new_end = rq.new_start + (rand48() & (mask >> 4)) + 1'b1;
      roll = $urandom_range(0, 99);
      if (roll < 12) rq.new_start = '0;
      else if (roll < 22) rq.new_end = '0;
      else if (roll < 26) rq.new_end = rq.new_start - (rand48() & (mask >> 4));
      else if (roll < 28) begin
        rq.new_start = '0;
        rq.new_end = '0;
      end else if (roll < 30) begin
        rq.new_start = TIME_MAX - (rand48() & 48'hF);
        rq.new_end = '0;
      end
    end
    return rq;
  endfunction

  // Offers one request beat, waits for it to be taken, then queues its
  // expected result.
  task automatic send(request_t rq, bit fixed, result_t given);
    result_t predicted;
    if (!calm && tx_gaps && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= pack_request(rq);
    s_tuser <= rq.kind;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = apply_request(rq);
    pending_results.push_back(fixed ? given : predicted);
  endtask

  function automatic int field_diff(string name, logic [TIME_W-1:0] exp_v,
                                    logic [TIME_W-1:0] act_v);
    if (exp_v === act_v) return 0;
    if (errors < PRINT_CAP)
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    return 1;
  endfunction

  // result side: compare every accepted beat with the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen = unpack_result(m_tdata);
      if (pending_results.size() == 0) begin
        if (errors < PRINT_CAP)
          $display("%0t: unexpected result beat, expected none, actual status %0d",
                   $time, seen.status);
        errors++;
      end else begin
        want = pending_results.pop_front();
        errors += field_diff("status", want.status, seen.status)
                + field_diff("position", want.position, seen.position)
                + field_diff("entry_id", want.entry_id, seen.entry_id)
                + field_diff("entry_start", want.entry_start, seen.entry_start)
                + field_diff("entry_end", want.entry_end, seen.entry_end)
                + field_diff("entry_tag", want.entry_tag, seen.entry_tag)
                + field_diff("entry_count", want.entry_count, seen.entry_count);
      end
    end
  end

  // result side ready: random stalls, one long hold-off, none at the end
  initial begin
    wait (rst === 1'b0);
    forever begin
      if (calm) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if ($urandom_range(0, 2) != 0) begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end else begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  // watchdog on cycles without any beat moving
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("time_interval_table_tb failed");
      $finish;
    end
  end

  initial begin
    plan_row_t plan[$];
    result_t   none;
    none = outcome(ST_OK, '0, '0, '0, '0, '0, '0);

    // empty table, a 0-0 entry that blocks everything, clear, unused kind
    plan.push_back('{request(KIND_LOOKUP, 0, 0, 0, 5, 0), 1'b1,
                     outcome(ST_NO_MATCH, 0, 0, 0, 0, 0, 1'd0)});
    plan.push_back('{request(KIND_ADD, 0, 0, 16'hFFFF, 0, 0), 1'b1,
                     outcome(ST_OK, 0, 0, 0, 0, 16'hFFFF, 1)});
    plan.push_back('{request(KIND_ADD, 100, 200, 1, 0, 0), 1'b1,
                     outcome(ST_OVERLAP, 0, 0, 0, 0, 0, 1)});
    plan.push_back('{request(KIND_ADD, 0, 0, 2, 0, 0), 1'b1,
                     outcome(ST_ZERO, 0, 0, 0, 0, 0, 1)});
    plan.push_back('{request(KIND_LOOKUP, 0, 0, 0, TIME_MAX, 0), 1'b1,
                     outcome(ST_OK, 0, 0, 0, 0, 16'hFFFF, 1)});
    plan.push_back('{request(KIND_LOOKUP, 0, 0, 0, 7, 15), 1'b1,
                     outcome(ST_NO_MATCH, 0, 0, 0, 0, 0, 1)});
    plan.push_back('{request(KIND_CLEAR, TIME_MAX, TIME_MAX, 16'hFFFF, TIME_MAX, 15), 1'b1,
                     outcome(ST_OK, 0, 0, 0, 0, 0, 0)});
    plan.push_back('{request(KIND_NONE, TIME_MAX, TIME_MAX, 16'hFFFF, TIME_MAX, 15), 1'b1,
                     outcome(ST_OK, 0, 0, 0, 0, 0, 0)});
    // end not above start
    plan.push_back('{request(KIND_ADD, 500, 400, 3, 0, 0), 1'b1,
                     outcome(ST_ORDER, 0, 0, 0, 0, 0, 0)});
    plan.push_back('{request(KIND_ADD, 500, 500, 3, 0, 0), 1'b1,
                     outcome(ST_ORDER, 0, 0, 0, 0, 0, 0)});
    // serial keeps counting across a clear
    plan.push_back('{request(KIND_ADD, TIME_MAX, 0, 0, 0, 0), 1'b1,
                     outcome(ST_OK, 0, 1, TIME_MAX, 0, 0, 1)});
    plan.push_back('{request(KIND_ADD, TIME_MAX - 1, TIME_MAX, 16'h8001, 0, 0), 1'b0, none});
    plan.push_back('{request(KIND_ADD, 1000, 2000, 16'h1234, 0, 0), 1'b0, none});
    plan.push_back('{request(KIND_ADD, 0, 500, 5, 0, 0), 1'b0, none});
    plan.push_back('{request(KIND_ADD, 0, 0, 6, 0, 0), 1'b1,
                     outcome(ST_ZERO, 0, 0, 0, 0, 0, 4)});
    // open end takes the next start
    plan.push_back('{request(KIND_ADD, 2000, 0, 7, 0, 0), 1'b0, none});
    // open start moved past an entry starting at 0, then checked as given
    plan.push_back('{request(KIND_ADD, 0, 700, 8, 0, 0), 1'b0, none});
    plan.push_back('{request(KIND_ADD, 0, 400, 9, 0, 0), 1'b0, none});
    plan.push_back('{request(KIND_ADD, 1500, 1600, 10, 0, 0), 1'b0, none});
    plan.push_back('{request(KIND_ADD, 1, 0, 11, 0, 0), 1'b0, none});
    plan.push_back('{request(KIND_LOOKUP, 0, 0, 0, 600, 0), 1'b0, none});
    plan.push_back('{request(KIND_LOOKUP, 0, 0, 0, 600, 2), 1'b0, none});
    plan.push_back('{request(KIND_LOOKUP, 0, 0, 0, 0, 0), 1'b0, none});
    plan.push_back('{request(KIND_LOOKUP, 0, 0, 0, TIME_MAX, 0), 1'b0, none});

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) send(plan[i].rq, plan[i].fixed, plan[i].want);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) tx_gaps = ($urandom_range(0, 2) != 0);
      if (n == 400) hold_req = 1'b1;
      if (n == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      send(make_request(), 1'b0, none);
    end
    s_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("time_interval_table_tb passed");
    end else begin
      $display("time_interval_table_tb failed");
    end
    $finish;
  end

endmodule

>>> files.f
design/tit_pkg.sv
design/tit_ctrl.sv
design/tit_dp.sv
design/time_interval_table.sv
tb/sv/time_interval_table_tb.sv
